[sv/gffp_pkg.sv]
`default_nettype none

package gffp_pkg;

  localparam int MAX_COLS = 16;
  localparam int MAX_ROWS = 16;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COLS_W = $clog2(MAX_COLS + 1);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);

  localparam int FUNC_W    = 2;
  localparam int XY_W      = 4;
  localparam int DIM_W     = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  // wide enough for any position plus any dimension
  localparam int SUM_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 5'd16;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   op;
    logic [XY_W-1:0]     pos_x;
    logic [XY_W-1:0]     pos_y;
    logic [DIM_W-1:0]    rect_w;
    logic [DIM_W-1:0]    rect_h;
    logic [COLS_W-1:0]   gw;
    logic [ROWS_W-1:0]   gh;
    logic                dims_ok;
    logic                can_rot;
    logic                mark_ok;
    logic [MAX_COLS-1:0] mark_mask;
    logic [ROWS_W-1:0]   mark_end;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic [XY_W-1:0]  place_x;
    logic [XY_W-1:0]  place_y;
    logic             rotated;
    logic [DIM_W-1:0] placed_width;
    logic [DIM_W-1:0] placed_height;
  } res_t;

  function automatic logic [MAX_COLS-1:0] low_ones(input logic [SUM_W-1:0] n);
    logic [MAX_COLS-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      m[i] = (SUM_W'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [SUM_W-1:0] min_sum(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[sv/grid_first_fit_placer.sv]
// A place with nonzero dimensions scans the gh rows in use, then writes the h rows of
//   the placed rectangle if one fits; a mark writes the rows marked; clear and no-op respond.
// One request at a time in the engine, which reads or writes one bitmap row per cycle
//   while it scans or fills.
// Reset (synchronous, rst_n low): all cells free, grid 16 x 16, both queues empty.
`default_nettype none

module grid_first_fit_placer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [gffp_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [gffp_pkg::XY_W-1:0]      in_pos_x,
  input  wire logic [gffp_pkg::XY_W-1:0]      in_pos_y,
  input  wire logic [gffp_pkg::DIM_W-1:0]     in_rect_width,
  input  wire logic [gffp_pkg::DIM_W-1:0]     in_rect_height,
  output logic                                empty,
  input  wire logic                           pop,
  output logic                                out_found,
  output logic [gffp_pkg::XY_W-1:0]           out_place_x,
  output logic [gffp_pkg::XY_W-1:0]           out_place_y,
  output logic                                out_rotated,
  output logic [gffp_pkg::DIM_W-1:0]          out_placed_width,
  output logic [gffp_pkg::DIM_W-1:0]          out_placed_height,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gffp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gffp_pkg::CFG_W-1:0]     cfg_data
);

  logic           cmd_vld;
  gffp_pkg::cmd_t cmd;
  logic           cmd_pop;
  logic           res_push;
  gffp_pkg::res_t res;
  logic           res_full;

  gffp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_func        (in_func),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd_vld        (cmd_vld),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  gffp_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  gffp_outq u_outq (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_push          (res_push),
    .res               (res),
    .res_full          (res_full),
    .empty             (empty),
    .pop               (pop),
    .out_found         (out_found),
    .out_place_x       (out_place_x),
    .out_place_y       (out_place_y),
    .out_rotated       (out_rotated),
    .out_placed_width  (out_placed_width),
    .out_placed_height (out_placed_height)
  );

endmodule

`default_nettype wire

[sv/gffp_front.sv]
`default_nettype none

module gffp_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [gffp_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [gffp_pkg::XY_W-1:0]      in_pos_x,
  input  wire logic [gffp_pkg::XY_W-1:0]      in_pos_y,
  input  wire logic [gffp_pkg::DIM_W-1:0]     in_rect_width,
  input  wire logic [gffp_pkg::DIM_W-1:0]     in_rect_height,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gffp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gffp_pkg::CFG_W-1:0]     cfg_data,
  output logic                                cmd_vld,
  output gffp_pkg::cmd_t                      cmd,
  input  wire logic                           cmd_pop
);

  logic [gffp_pkg::CFG_W-1:0] gw_reg_r;
  logic [gffp_pkg::CFG_W-1:0] gh_reg_r;

  gffp_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;

  gffp_pkg::cmd_t             cmd_new;
  logic [gffp_pkg::SUM_W-1:0] gw_s;
  logic [gffp_pkg::SUM_W-1:0] gh_s;
  logic [gffp_pkg::SUM_W-1:0] px_s;
  logic [gffp_pkg::SUM_W-1:0] py_s;
  logic [gffp_pkg::SUM_W-1:0] rw_s;
  logic [gffp_pkg::SUM_W-1:0] rh_s;
  logic [gffp_pkg::SUM_W-1:0] col_cnt;
  logic [gffp_pkg::SUM_W-1:0] row_end;
  logic                       do_push;
  logic                       do_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_reg_r <= gffp_pkg::GRID_WIDTH_RST;
      gh_reg_r <= gffp_pkg::GRID_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        gffp_pkg::REG_GRID_WIDTH:  gw_reg_r <= cfg_data;
        gffp_pkg::REG_GRID_HEIGHT: gh_reg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify the request and precompute what the engine needs
  always_comb begin
    gw_s = gffp_pkg::min_sum(gffp_pkg::SUM_W'(gw_reg_r), gffp_pkg::SUM_W'(gffp_pkg::MAX_COLS));
    gh_s = gffp_pkg::min_sum(gffp_pkg::SUM_W'(gh_reg_r), gffp_pkg::SUM_W'(gffp_pkg::MAX_ROWS));
    px_s = gffp_pkg::SUM_W'(in_pos_x);
    py_s = gffp_pkg::SUM_W'(in_pos_y);
    rw_s = gffp_pkg::SUM_W'(in_rect_width);
    rh_s = gffp_pkg::SUM_W'(in_rect_height);
    col_cnt = gffp_pkg::min_sum(rw_s, gw_s - px_s);
    row_end = gffp_pkg::min_sum(gh_s, py_s + rh_s);

    cmd_new.op        = in_func;
    cmd_new.pos_x     = in_pos_x;
    cmd_new.pos_y     = in_pos_y;
    cmd_new.rect_w    = in_rect_width;
    cmd_new.rect_h    = in_rect_height;
    cmd_new.gw        = gffp_pkg::COLS_W'(gw_s);
    cmd_new.gh        = gffp_pkg::ROWS_W'(gh_s);
    cmd_new.dims_ok   = (in_rect_width != '0) && (in_rect_height != '0);
    cmd_new.can_rot   = (in_rect_width != in_rect_height);
    cmd_new.mark_ok   = cmd_new.dims_ok && (px_s < gw_s) && (py_s < gh_s);
    cmd_new.mark_mask = gffp_pkg::low_ones(col_cnt) << in_pos_x;
    cmd_new.mark_end  = gffp_pkg::ROWS_W'(row_end);
  end

  assign full    = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign cmd     = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = cmd_pop && cmd_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/gffp_engine.sv]
`default_nettype none

module gffp_engine (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_vld,
  input  wire gffp_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                res_push,
  output gffp_pkg::res_t      res,
  input  wire logic           res_full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  localparam int DR_W = gffp_pkg::ROWS_W;

  logic [1:0]                    state_r, state_nxt;
  gffp_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [gffp_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic                          scan_left_r, scan_left_nxt;
  logic                          eval_vld_r, eval_vld_nxt;
  logic [gffp_pkg::ROW_W-1:0]    eval_row_r, eval_row_nxt;
  logic [DR_W-1:0]               dr_r [gffp_pkg::MAX_COLS];
  logic [DR_W-1:0]               dr_nxt [gffp_pkg::MAX_COLS];
  logic                          best_vld_r, best_vld_nxt;
  logic [gffp_pkg::COL_W-1:0]    best_x_r, best_x_nxt;
  logic [gffp_pkg::ROW_W-1:0]    best_y_r, best_y_nxt;
  logic                          best_rot_r, best_rot_nxt;
  logic [gffp_pkg::ROWS_W-1:0]   fill_row_r, fill_row_nxt;
  logic [gffp_pkg::ROWS_W-1:0]   fill_end_r, fill_end_nxt;
  logic [gffp_pkg::MAX_COLS-1:0] fill_mask_r, fill_mask_nxt;
  gffp_pkg::res_t                res_r, res_nxt;
  logic [gffp_pkg::MAX_COLS-1:0] occ_r [gffp_pkg::MAX_ROWS];
  logic [gffp_pkg::MAX_COLS-1:0] occ_nxt [gffp_pkg::MAX_ROWS];

  logic [gffp_pkg::MAX_COLS-1:0] row_bits;
  logic [DR_W-1:0]               dr_row [gffp_pkg::MAX_COLS];
  logic [gffp_pkg::MAX_COLS-1:0] g_u, g_r, m_u, m_r, ok_u, ok_r;
  logic                          hit;
  logic [gffp_pkg::COL_W-1:0]    hit_x;
  logic [gffp_pkg::DIM_W-1:0]    best_w, best_h;
  logic [gffp_pkg::SUM_W-1:0]    bx_s, by_s;

  // column run lengths of free cells, from the scanned row toward higher row numbers
  always_comb begin
    row_bits = occ_r[row_r];
    m_u = gffp_pkg::low_ones(gffp_pkg::SUM_W'(cmd_r.rect_w));
    m_r = gffp_pkg::low_ones(gffp_pkg::SUM_W'(cmd_r.rect_h));
    for (int x = 0; x < gffp_pkg::MAX_COLS; x++) begin
      if ((gffp_pkg::SUM_W'(x) < gffp_pkg::SUM_W'(cmd_r.gw)) && !row_bits[x]) begin
        dr_row[x] = dr_r[x] + 1'b1;
      end else begin
        dr_row[x] = '0;
      end
      g_u[x] = gffp_pkg::SUM_W'(dr_r[x]) >= gffp_pkg::SUM_W'(cmd_r.rect_h);
      g_r[x] = gffp_pkg::SUM_W'(dr_r[x]) >= gffp_pkg::SUM_W'(cmd_r.rect_w);
    end
    for (int x = 0; x < gffp_pkg::MAX_COLS; x++) begin
      ok_u[x] = cmd_r.dims_ok
             && (gffp_pkg::SUM_W'(x) + gffp_pkg::SUM_W'(cmd_r.rect_w)
                 <= gffp_pkg::SUM_W'(cmd_r.gw))
             && (((g_u >> x) & m_u) == m_u);
      ok_r[x] = cmd_r.dims_ok && cmd_r.can_rot
             && (gffp_pkg::SUM_W'(x) + gffp_pkg::SUM_W'(cmd_r.rect_h)
                 <= gffp_pkg::SUM_W'(cmd_r.gw))
             && (((g_r >> x) & m_r) == m_r);
    end
    hit   = |(ok_u | ok_r);
    hit_x = '0;
    for (int x = gffp_pkg::MAX_COLS - 1; x >= 0; x--) begin
      if (ok_u[x] || ok_r[x]) begin
        hit_x = gffp_pkg::COL_W'(x);
      end
    end
  end

  always_comb begin
    best_w = best_rot_r ? cmd_r.rect_h : cmd_r.rect_w;
    best_h = best_rot_r ? cmd_r.rect_w : cmd_r.rect_h;
    bx_s   = gffp_pkg::SUM_W'(best_x_r);
    by_s   = gffp_pkg::SUM_W'(best_y_r);
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    scan_left_nxt = scan_left_r;
    eval_vld_nxt  = eval_vld_r;
    eval_row_nxt  = eval_row_r;
    dr_nxt        = dr_r;
    best_vld_nxt  = best_vld_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    best_rot_nxt  = best_rot_r;
    fill_row_nxt  = fill_row_r;
    fill_end_nxt  = fill_end_r;
    fill_mask_nxt = fill_mask_r;
    res_nxt       = res_r;
    occ_nxt       = occ_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          res_nxt = '0;
          case (cmd.op)
            gffp_pkg::FUNC_PLACE: begin
              if (cmd.dims_ok && (cmd.gh != '0)) begin
                row_nxt       = gffp_pkg::ROW_W'(cmd.gh - 1'b1);
                scan_left_nxt = 1'b1;
                eval_vld_nxt  = 1'b0;
                best_vld_nxt  = 1'b0;
                for (int x = 0; x < gffp_pkg::MAX_COLS; x++) begin
                  dr_nxt[x] = '0;
                end
                state_nxt = ST_SCAN;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            gffp_pkg::FUNC_MARK: begin
              res_nxt.found         = 1'b1;
              res_nxt.place_x       = cmd.pos_x;
              res_nxt.place_y       = cmd.pos_y;
              res_nxt.placed_width  = cmd.rect_w;
              res_nxt.placed_height = cmd.rect_h;
              fill_row_nxt  = gffp_pkg::ROWS_W'(cmd.pos_y);
              fill_end_nxt  = cmd.mark_end;
              fill_mask_nxt = cmd.mark_mask;
              state_nxt     = cmd.mark_ok ? ST_FILL : ST_RESP;
            end
            gffp_pkg::FUNC_CLEAR: begin
              for (int r = 0; r < gffp_pkg::MAX_ROWS; r++) begin
                occ_nxt[r] = '0;
              end
              state_nxt = ST_RESP;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_left_r) begin
          dr_nxt        = dr_row;
          eval_vld_nxt  = 1'b1;
          eval_row_nxt  = row_r;
          scan_left_nxt = (row_r != '0);
          row_nxt       = row_r - 1'b1;
        end else begin
          eval_vld_nxt = 1'b0;
        end
        // later hits are at lower row numbers, so overwrite
        if (eval_vld_r && hit) begin
          best_vld_nxt = 1'b1;
          best_x_nxt   = hit_x;
          best_y_nxt   = eval_row_r;
          best_rot_nxt = !ok_u[hit_x];
        end
        if (!scan_left_r && !eval_vld_r) begin
          if (best_vld_r) begin
            res_nxt.found         = 1'b1;
            res_nxt.place_x       = bx_s[gffp_pkg::XY_W-1:0];
            res_nxt.place_y       = by_s[gffp_pkg::XY_W-1:0];
            res_nxt.rotated       = best_rot_r;
            res_nxt.placed_width  = best_w;
            res_nxt.placed_height = best_h;
            fill_row_nxt  = gffp_pkg::ROWS_W'(best_y_r);
            fill_end_nxt  = gffp_pkg::ROWS_W'(by_s + gffp_pkg::SUM_W'(best_h));
            fill_mask_nxt = gffp_pkg::low_ones(gffp_pkg::SUM_W'(best_w)) << best_x_r;
            state_nxt     = ST_FILL;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_FILL: begin
        occ_nxt[fill_row_r[gffp_pkg::ROW_W-1:0]] =
          occ_r[fill_row_r[gffp_pkg::ROW_W-1:0]] | fill_mask_r;
        fill_row_nxt = fill_row_r + 1'b1;
        if (fill_row_nxt == fill_end_r) begin
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        res_push = 1'b1;
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    row_r       <= row_nxt;
    eval_row_r  <= eval_row_nxt;
    dr_r        <= dr_nxt;
    best_x_r    <= best_x_nxt;
    best_y_r    <= best_y_nxt;
    best_rot_r  <= best_rot_nxt;
    fill_row_r  <= fill_row_nxt;
    fill_end_r  <= fill_end_nxt;
    fill_mask_r <= fill_mask_nxt;
    res_r       <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_left_r <= 1'b0;
      eval_vld_r  <= 1'b0;
      best_vld_r  <= 1'b0;
      for (int r = 0; r < gffp_pkg::MAX_ROWS; r++) begin
        occ_r[r] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      scan_left_r <= scan_left_nxt;
      eval_vld_r  <= eval_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      occ_r       <= occ_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (fill_row_r < fill_end_r))
    else $error("fill row past end of rectangle");

  a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && scan_left_r)
      |-> (gffp_pkg::SUM_W'(row_r) < gffp_pkg::SUM_W'(cmd_r.gh)))
    else $error("scan row outside configured grid");

  a_found_source: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.found)
      |-> (cmd_r.op == gffp_pkg::FUNC_PLACE || cmd_r.op == gffp_pkg::FUNC_MARK))
    else $error("found set for a request that cannot succeed");

  a_fill_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_FILL) |-> best_vld_r)
    else $error("fill started without a placement");
`endif

endmodule

`default_nettype wire

[sv/gffp_outq.sv]
`default_nettype none

module gffp_outq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        res_push,
  input  wire gffp_pkg::res_t              res,
  output logic                             res_full,
  output logic                             empty,
  input  wire logic                        pop,
  output logic                             out_found,
  output logic [gffp_pkg::XY_W-1:0]        out_place_x,
  output logic [gffp_pkg::XY_W-1:0]        out_place_y,
  output logic                             out_rotated,
  output logic [gffp_pkg::DIM_W-1:0]       out_placed_width,
  output logic [gffp_pkg::DIM_W-1:0]       out_placed_height
);

  gffp_pkg::res_t slot_r [2];
  gffp_pkg::res_t head;
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign head     = slot_r[rd_ptr_r];

  assign out_found         = head.found;
  assign out_place_x       = head.place_x;
  assign out_place_y       = head.place_y;
  assign out_rotated       = head.rotated;
  assign out_placed_width  = head.placed_width;
  assign out_placed_height = head.placed_height;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gffp_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [FUNC_W-1:0]    in_func = FUNC_NONE;
  logic [XY_W-1:0]      in_pos_x = '0;
  logic [XY_W-1:0]      in_pos_y = '0;
  logic [DIM_W-1:0]     in_rect_width = '0;
  logic [DIM_W-1:0]     in_rect_height = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 out_found;
  logic [XY_W-1:0]      out_place_x;
  logic [XY_W-1:0]      out_place_y;
  logic                 out_rotated;
  logic [DIM_W-1:0]     out_placed_width;
  logic [DIM_W-1:0]     out_placed_height;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  grid_first_fit_placer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_func           (in_func),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_rect_width     (in_rect_width),
    .in_rect_height    (in_rect_height),
    .empty             (empty),
    .pop               (pop),
    .out_found         (out_found),
    .out_place_x       (out_place_x),
    .out_place_y       (out_place_y),
    .out_rotated       (out_rotated),
    .out_placed_width  (out_placed_width),
    .out_placed_height (out_placed_height),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the grid and its registers
  logic [MAX_COLS-1:0] occ_rows [MAX_ROWS];
  logic [CFG_W-1:0]    cols_reg = GRID_WIDTH_RST;
  logic [CFG_W-1:0]    rows_reg = GRID_HEIGHT_RST;

  res_t pending_results [$];
  int   err_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   rx_hold_cycles = 0;

  initial begin
    for (int r = 0; r < MAX_ROWS; r++) begin
      occ_rows[r] = '0;
    end
  end

  function automatic int used_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int used_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic bit span_free(int x, int y, int w, int h, int gw, int gh);
    int          r;
    logic [31:0] m;
    if (w == 0 || h == 0) return 1'b0;
    if (x + w > gw || y + h > gh) return 1'b0;
    m = (32'd1 << w) - 32'd1;
    for (r = y; r < y + h; r++) begin
      if (((32'(occ_rows[r]) >> x) & m) != 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // set cells, clipped to the grid in use
  function automatic void occupy_span(int x, int y, int w, int h, int gw, int gh);
    int          r;
    int          cnt;
    logic [31:0] m;
    if (x >= gw || y >= gh || w == 0 || h == 0) return;
    cnt = (w < gw - x) ? w : gw - x;
    m = ((32'd1 << cnt) - 32'd1) << x;
    for (r = y; r < gh && r < y + h; r++) begin
      occ_rows[r] = occ_rows[r] | m[MAX_COLS-1:0];
    end
  endfunction

  function automatic res_t expected_placement(logic [FUNC_W-1:0] f, int px, int py,
                                              int rw, int rh);
    res_t res;
    int   gw;
    int   gh;
    int   x;
    int   y;
    int   r;
    res = '0;
    gw = used_cols();
    gh = used_rows();
    case (f)
      FUNC_PLACE: begin
        for (y = 0; y < gh && !res.found; y++) begin
          for (x = 0; x < gw && !res.found; x++) begin
            if (span_free(x, y, rw, rh, gw, gh)) begin
              res.placed_width  = DIM_W'(rw);
              res.placed_height = DIM_W'(rh);
              res.found         = 1'b1;
            end else if (rw != rh && span_free(x, y, rh, rw, gw, gh)) begin
              res.rotated       = 1'b1;
              res.placed_width  = DIM_W'(rh);
              res.placed_height = DIM_W'(rw);
              res.found         = 1'b1;
            end
            if (res.found) begin
              res.place_x = XY_W'(x);
              res.place_y = XY_W'(y);
              occupy_span(x, y, res.placed_width, res.placed_height, gw, gh);
            end
          end
        end
      end
      FUNC_MARK: begin
        occupy_span(px, py, rw, rh, gw, gh);
        res.found         = 1'b1;
        res.place_x       = XY_W'(px);
        res.place_y       = XY_W'(py);
        res.placed_width  = DIM_W'(rw);
        res.placed_height = DIM_W'(rh);
      end
      FUNC_CLEAR: begin
        for (r = 0; r < MAX_ROWS; r++) begin
          occ_rows[r] = '0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      pop <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result with no request pending, actual found=%0d x=%0d y=%0d",
                 $time, out_found, out_place_x, out_place_y);
      end else begin : compare
        res_t want;
        want = pending_results.pop_front();
        check_field("found", want.found, out_found);
        check_field("place_x", want.place_x, out_place_x);
        check_field("place_y", want.place_y, out_place_y);
        check_field("rotated", want.rotated, out_rotated);
        check_field("placed_width", want.placed_width, out_placed_width);
        check_field("placed_height", want.placed_height, out_placed_height);
      end
    end
  end

  // entered and left at a falling edge; push stays high for back-to-back requests
  task automatic send_req(logic [FUNC_W-1:0] f, int px, int py, int w, int h);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push           <= 1'b1;
    in_func        <= f;
    in_pos_x       <= XY_W'(px);
    in_pos_y       <= XY_W'(py);
    in_rect_width  <= DIM_W'(w);
    in_rect_height <= DIM_W'(h);
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(expected_placement(f, px, py, w, h));
    @(negedge clk);
  endtask

  // drop push and wait until every result is back
  task automatic quiesce();
    push <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_grid(int cols, int rows);
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= CFG_W'(cols);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cols_reg = CFG_W'(cols);
    @(negedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= CFG_W'(rows);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rows_reg = CFG_W'(rows);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly small rectangles so that places succeed; zero and oversize now and then
  function automatic int rand_dim();
    int k;
    k = $urandom_range(99);
    if (k < 80) return $urandom_range(4, 1);
    if (k < 92) return $urandom_range(16, 5);
    if (k < 96) return 0;
    return $urandom_range(31, 17);
  endfunction

  task automatic send_random();
    int               k;
    logic [FUNC_W-1:0] f;
    k = $urandom_range(99);
    if (k < 64) f = FUNC_PLACE;
    else if (k < 84) f = FUNC_MARK;
    else if (k < 91) f = FUNC_CLEAR;
    else f = FUNC_NONE;
    send_req(f, $urandom_range(15), $urandom_range(15), rand_dim(), rand_dim());
  endtask

  function automatic int rand_grid_size();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(16, 6);
    if (k < 85) return $urandom_range(5, 1);
    if (k < 90) return 0;
    return $urandom_range(31, 17);
  endfunction

  task automatic test_reset_state();
    send_req(FUNC_PLACE, 0, 0, 16, 16);
    send_req(FUNC_PLACE, 0, 0, 1, 1);
    send_req(FUNC_CLEAR, 0, 0, 0, 0);
    quiesce();
  endtask

  task automatic test_directed();
    // zero and oversize dimensions fail
    send_req(FUNC_PLACE, 0, 0, 0, 3);
    send_req(FUNC_PLACE, 0, 0, 3, 0);
    send_req(FUNC_PLACE, 0, 0, 17, 1);
    send_req(FUNC_PLACE, 15, 15, 31, 31);
    // leave two free rows so that only the rotated shape fits
    send_req(FUNC_MARK, 0, 0, 16, 14);
    send_req(FUNC_PLACE, 0, 0, 2, 3);
    send_req(FUNC_PLACE, 0, 0, 2, 2);
    send_req(FUNC_PLACE, 0, 0, 3, 3);
    send_req(FUNC_PLACE, 0, 0, 1, 1);
    send_req(FUNC_MARK, 15, 15, 31, 31);
    send_req(FUNC_MARK, 0, 0, 0, 5);
    send_req(FUNC_MARK, 7, 9, 5, 0);
    send_req(FUNC_NONE, 15, 15, 31, 31);
    send_req(FUNC_NONE, 0, 0, 0, 0);
    send_req(FUNC_CLEAR, 15, 15, 31, 31);
    send_req(FUNC_PLACE, 0, 0, 1, 16);
    send_req(FUNC_PLACE, 0, 0, 16, 1);
    send_req(FUNC_PLACE, 0, 0, 16, 15);
    send_req(FUNC_CLEAR, 0, 0, 0, 0);
    quiesce();
  endtask

  task automatic test_grid_sizes();
    int sizes [10][2];
    sizes = '{'{1, 1}, '{0, 16}, '{16, 0}, '{31, 31}, '{17, 5}, '{5, 17},
              '{4, 4}, '{16, 16}, '{3, 7}, '{16, 16}};
    foreach (sizes[i]) begin
      quiesce();
      set_grid(sizes[i][0], sizes[i][1]);
      send_req(FUNC_PLACE, 0, 0, 1, 1);
      send_req(FUNC_MARK, 15, 15, 2, 2);
      repeat (8) send_random();
    end
    quiesce();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiesce();
    set_grid(16, 16);
    // hold results off while requests keep coming
    rx_hold_cycles = 400;
    repeat (40) send_random();
    quiesce();
  endtask

  task automatic test_random();
    int idle_pct [4];
    int stall_pct [4];
    idle_pct  = '{0, 59, 0, 24};
    stall_pct = '{0, 0, 59, 24};
    for (int p = 0; p < 4; p++) begin
      quiesce();
      if (p == 0) set_grid(16, 16);
      else set_grid(rand_grid_size(), rand_grid_size());
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int n = 0; n < 250; n++) begin
        send_random();
        if (n == 125) begin
          quiesce();
          set_grid(rand_grid_size(), rand_grid_size());
        end
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiesce();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_directed();
    test_grid_sizes();
    test_backpressure();
    test_random();
    quiesce();
    repeat (64) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/gffp_pkg.sv
sv/gffp_front.sv
sv/gffp_engine.sv
sv/gffp_outq.sv
sv/grid_first_fit_placer.sv
dv/testbench.sv
